/* sv/mpd_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package mpd_pkg;

    // Field widths of the streams
    localparam int PIN_W       = 16;
    localparam int CNT_W       = 8;
    localparam int OP_W        = 3;
    localparam int KIND_W      = 2;
    localparam int S_TDATA_W   = 24;
    localparam int M_TDATA_W   = 24;
    localparam int S_PAYLOAD_W = PIN_W + 1;
    localparam int M_PAYLOAD_W = PIN_W + 2;

    // Reload value of debounce_ticks after reset
    localparam logic [CNT_W-1:0] DEBOUNCE_RESET = 8'd10;

    // Operation codes on the input stream
    typedef enum logic [OP_W-1:0] {
        OP_TICK  = 3'd0,
        OP_EDGE  = 3'd1,
        OP_SUB   = 3'd2,
        OP_UNSUB = 3'd3,
        OP_QUERY = 3'd4
    } op_t;

    // Result kinds on the output stream
    typedef enum logic [KIND_W-1:0] {
        KIND_EVENT = 2'd0,
        KIND_SUB   = 2'd1,
        KIND_UNSUB = 2'd2,
        KIND_QUERY = 2'd3
    } kind_t;

    // Controller states
    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_EXEC = 2'd1,
        ST_WALK = 2'd2
    } state_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic load_in;
        logic exec_tick;
        logic exec_edge;
        logic exec_sub;
        logic exec_unsub;
        logic exec_query;
        logic step;
        logic emit_event;
    } cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        op_t  op;
        logic out_free;
        logic fire_here;
        logic idx_end;
    } stat_t;

endpackage

`default_nettype wire

/* sv/mpd_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none

module mpd_ctrl (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_tvalid,
    output logic               s_tready,
    input  wire mpd_pkg::stat_t stat,
    output mpd_pkg::cmd_t      cmd
);

    mpd_pkg::state_t state_reg;
    mpd_pkg::state_t state_next;

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= mpd_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            mpd_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = mpd_pkg::ST_EXEC;
                end
            end
            mpd_pkg::ST_EXEC: begin
                case (stat.op)
                    mpd_pkg::OP_TICK: state_next = mpd_pkg::ST_WALK;
                    mpd_pkg::OP_EDGE: state_next = mpd_pkg::ST_IDLE;
                    mpd_pkg::OP_SUB, mpd_pkg::OP_UNSUB, mpd_pkg::OP_QUERY: begin
                        if (stat.out_free) begin
                            state_next = mpd_pkg::ST_IDLE;
                        end
                    end
                    default: state_next = mpd_pkg::ST_IDLE;
                endcase
            end
            mpd_pkg::ST_WALK: begin
                // hold while a firing slot waits for the output register
                if ((!stat.fire_here || stat.out_free) && stat.idx_end) begin
                    state_next = mpd_pkg::ST_IDLE;
                end
            end
            default: state_next = mpd_pkg::ST_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        cmd      = '0;
        s_tready = 1'b0;
        unique case (state_reg)
            mpd_pkg::ST_IDLE: begin
                s_tready    = 1'b1;
                cmd.load_in = s_tvalid;
            end
            mpd_pkg::ST_EXEC: begin
                case (stat.op)
                    mpd_pkg::OP_TICK:  cmd.exec_tick  = 1'b1;
                    mpd_pkg::OP_EDGE:  cmd.exec_edge  = 1'b1;
                    mpd_pkg::OP_SUB:   cmd.exec_sub   = stat.out_free;
                    mpd_pkg::OP_UNSUB: cmd.exec_unsub = stat.out_free;
                    mpd_pkg::OP_QUERY: cmd.exec_query = stat.out_free;
                    default: ;
                endcase
            end
            mpd_pkg::ST_WALK: begin
                if (!stat.fire_here || stat.out_free) begin
                    cmd.step       = 1'b1;
                    cmd.emit_event = stat.fire_here;
                end
            end
            default: ;
        endcase
    end

endmodule

`default_nettype wire

/* sv/mpd_dp.sv */
`timescale 1ns / 1ps
`default_nettype none

module mpd_dp #(
    parameter int SLOTS = 16
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire mpd_pkg::cmd_t                   cmd,
    output mpd_pkg::stat_t                       stat,
    input  wire logic [mpd_pkg::S_TDATA_W-1:0]   s_tdata,
    input  wire logic [mpd_pkg::OP_W-1:0]        s_tuser,
    input  wire logic                            cfg_we,
    input  wire logic [mpd_pkg::CNT_W-1:0]       cfg_wdata,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic [mpd_pkg::M_TDATA_W-1:0]        m_tdata,
    output logic [mpd_pkg::KIND_W-1:0]           m_tuser,
    output logic                                 m_tlast
);

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    // Captured input item
    mpd_pkg::op_t                op_reg;
    logic [mpd_pkg::PIN_W-1:0]   pin_reg;
    logic                        init_reg;

    logic [mpd_pkg::CNT_W-1:0]   debounce_reg;

    // Slot table
    logic [SLOTS-1:0]            used_reg, used_next;
    logic [SLOTS-1:0]            raw_reg, raw_next;
    logic [SLOTS-1:0]            rep_reg, rep_next;
    logic [SLOTS-1:0]            fire_reg, fire_next;
    logic [mpd_pkg::PIN_W-1:0]   slot_pin_reg [SLOTS];
    logic [mpd_pkg::PIN_W-1:0]   slot_pin_next [SLOTS];
    logic [mpd_pkg::CNT_W-1:0]   cnt_reg [SLOTS];
    logic [mpd_pkg::CNT_W-1:0]   cnt_next [SLOTS];

    logic [IDX_W-1:0]            idx_reg, idx_next;

    // Output register
    logic                        out_valid_reg, out_valid_next;
    mpd_pkg::kind_t              out_kind_reg, out_kind_next;
    logic [mpd_pkg::PIN_W-1:0]   out_pin_reg, out_pin_next;
    logic                        out_level_reg, out_level_next;
    logic                        out_ok_reg, out_ok_next;
    logic                        out_last_reg, out_last_next;
    logic                        out_load;

    logic                        match_found, free_found;
    logic [IDX_W-1:0]            match_idx, free_idx;
    logic [SLOTS-1:0]            fire_left;

    // Find the lowest used slot holding the pin and the lowest free slot
    always_comb begin
        match_found = 1'b0;
        match_idx   = '0;
        free_found  = 1'b0;
        free_idx    = '0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (used_reg[i] && (slot_pin_reg[i] == pin_reg)) begin
                match_found = 1'b1;
                match_idx   = IDX_W'(i);
            end
            if (!used_reg[i]) begin
                free_found = 1'b1;
                free_idx   = IDX_W'(i);
            end
        end
    end

    // Firing slots still to transfer after the current one
    always_comb begin
        fire_left          = fire_reg;
        fire_left[idx_reg] = 1'b0;
    end

    // Slot table update
    always_comb begin
        used_next     = used_reg;
        raw_next      = raw_reg;
        rep_next      = rep_reg;
        fire_next     = fire_reg;
        slot_pin_next = slot_pin_reg;
        cnt_next      = cnt_reg;
        idx_next      = idx_reg;

        if (cmd.exec_tick) begin
            idx_next = '0;
            for (int i = 0; i < SLOTS; i++) begin
                fire_next[i] = 1'b0;
                if (cnt_reg[i] != '0) begin
                    cnt_next[i] = cnt_reg[i] - 1'b1;
                    if ((cnt_reg[i] == mpd_pkg::CNT_W'(1)) && (raw_reg[i] != rep_reg[i])) begin
                        rep_next[i]  = ~rep_reg[i];
                        fire_next[i] = 1'b1;
                    end
                end
            end
        end

        if (cmd.step) begin
            fire_next = fire_left;
            idx_next  = idx_reg + 1'b1;
        end

        if (cmd.exec_edge && match_found) begin
            cnt_next[match_idx] = debounce_reg;
            raw_next[match_idx] = ~raw_reg[match_idx];
        end

        if (cmd.exec_sub && free_found) begin
            used_next[free_idx]     = 1'b1;
            slot_pin_next[free_idx] = pin_reg;
            raw_next[free_idx]      = init_reg;
            rep_next[free_idx]      = 1'b0;
            cnt_next[free_idx]      = '0;
        end

        if (cmd.exec_unsub && match_found) begin
            used_next[match_idx]     = 1'b0;
            slot_pin_next[match_idx] = '0;
            raw_next[match_idx]      = 1'b0;
            rep_next[match_idx]      = 1'b0;
            cnt_next[match_idx]      = '0;
        end
    end

    // Output register load
    always_comb begin
        out_load       = cmd.emit_event | cmd.exec_sub | cmd.exec_unsub | cmd.exec_query;
        out_kind_next  = out_kind_reg;
        out_pin_next   = out_pin_reg;
        out_level_next = out_level_reg;
        out_ok_next    = out_ok_reg;
        out_last_next  = out_last_reg;
        priority if (cmd.emit_event) begin
            out_kind_next  = mpd_pkg::KIND_EVENT;
            out_pin_next   = slot_pin_reg[idx_reg];
            out_level_next = rep_reg[idx_reg];
            out_ok_next    = 1'b1;
            out_last_next  = (fire_left == '0);
        end else if (cmd.exec_sub) begin
            out_kind_next  = mpd_pkg::KIND_SUB;
            out_pin_next   = pin_reg;
            out_level_next = 1'b0;
            out_ok_next    = free_found;
            out_last_next  = 1'b1;
        end else if (cmd.exec_unsub) begin
            out_kind_next  = mpd_pkg::KIND_UNSUB;
            out_pin_next   = pin_reg;
            out_level_next = 1'b0;
            out_ok_next    = match_found;
            out_last_next  = 1'b1;
        end else if (cmd.exec_query) begin
            out_kind_next  = mpd_pkg::KIND_QUERY;
            out_pin_next   = pin_reg;
            out_level_next = match_found & raw_reg[match_idx];
            out_ok_next    = match_found;
            out_last_next  = 1'b1;
        end else begin
            out_kind_next  = out_kind_reg;
        end

        if (out_load) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    // Control and table registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            used_reg      <= '0;
            raw_reg       <= '0;
            rep_reg       <= '0;
            fire_reg      <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
            debounce_reg  <= mpd_pkg::DEBOUNCE_RESET;
            for (int i = 0; i < SLOTS; i++) begin
                cnt_reg[i] <= '0;
            end
        end else begin
            used_reg      <= used_next;
            raw_reg       <= raw_next;
            rep_reg       <= rep_next;
            fire_reg      <= fire_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
            cnt_reg       <= cnt_next;
            if (cfg_we) begin
                debounce_reg <= cfg_wdata;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        slot_pin_reg  <= slot_pin_next;
        out_kind_reg  <= out_kind_next;
        out_pin_reg   <= out_pin_next;
        out_level_reg <= out_level_next;
        out_ok_reg    <= out_ok_next;
        out_last_reg  <= out_last_next;
        if (cmd.load_in) begin
            op_reg   <= mpd_pkg::op_t'(s_tuser);
            pin_reg  <= s_tdata[mpd_pkg::PIN_W-1:0];
            init_reg <= s_tdata[mpd_pkg::PIN_W];
        end
    end

    // Status to the controller
    assign stat.op        = op_reg;
    assign stat.out_free  = ~out_valid_reg | m_tready;
    assign stat.fire_here = fire_reg[idx_reg];
    assign stat.idx_end   = (idx_reg == IDX_W'(SLOTS - 1));

    // Result stream
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(mpd_pkg::M_TDATA_W - mpd_pkg::M_PAYLOAD_W){1'b0}},
                       out_ok_reg, out_level_reg, out_pin_reg};
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;

endmodule

`default_nettype wire

/* sv/multi_pin_edge_debouncer.sv */
// Each item is captured in ST_IDLE; no new item is taken until the block is back there.
// Subscribe, unsubscribe and query load their result in ST_EXEC; an edge only updates
// the slot table. A tick counts down in ST_EXEC, then walks all SLOTS slots in ST_WALK,
// emitting at most one event per cycle while the output register is free. A pending
// result with m_tready low holds ST_EXEC or the walk until it is taken.
// Reset (aresetn low, synchronous) clears the slot table and sets debounce_ticks to 10.
`timescale 1ns / 1ps
`default_nettype none

module multi_pin_edge_debouncer #(
    parameter int SLOTS = 16
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    // config: debounce_ticks
    input  wire logic                            cfg_we,
    input  wire logic [mpd_pkg::CNT_W-1:0]       cfg_wdata,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // [15:0] pin, [16] initial_level, rest zero
    input  wire logic [mpd_pkg::S_TDATA_W-1:0]   s_tdata,
    // [2:0] op
    input  wire logic [mpd_pkg::OP_W-1:0]        s_tuser,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // [15:0] pin_out, [16] level, [17] ok, rest zero
    output logic [mpd_pkg::M_TDATA_W-1:0]        m_tdata,
    // [1:0] kind
    output logic [mpd_pkg::KIND_W-1:0]           m_tuser,
    output logic                                 m_tlast
);

    mpd_pkg::cmd_t  cmd;
    mpd_pkg::stat_t stat;

    mpd_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    mpd_dp #(
        .SLOTS (SLOTS)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .stat      (stat),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule

`default_nettype wire
